FILE: sv/espd_pkg.sv
// shared types and constants for the escaped serial packet deframer
`timescale 1ns / 1ps
package espd_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int FILL_W      = $clog2(STORE_DEPTH + 1);

  localparam int CMDQ_DEPTH  = 4;
  localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

  localparam int OUT_DEPTH   = 4;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  localparam int PADDR_W     = 5;
  localparam int IDX_W       = 6;

  localparam logic [7:0] LOW_FIVE = 8'h1f;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_PACKET = 1'b1;

  typedef enum logic [2:0] {
    REG_END     = 3'd0,
    REG_NEWLINE = 3'd1,
    REG_ESCAPE  = 3'd2,
    REG_XOFF    = 3'd3,
    REG_XON     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] end_code;
    logic [7:0] newline_code;
    logic [7:0] escape_code;
    logic [7:0] xoff_code;
    logic [7:0] xon_code;
  } cfg_t;

  // work handed from front to back
  typedef struct packed {
    logic              kind;
    logic              tx_blocked;
    logic [FILL_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       data;
    logic [IDX_W-1:0] index;
    logic             last;
    logic             tx_blocked;
  } result_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

endpackage

FILE: sv/escaped_serial_packet_deframer.sv
// top level of the escaped serial packet deframer with xon/xoff handling
// path: a status result passes the command queue and then the result queue; packet bytes
// are read from the store once the back takes the packet command from the command queue
// throughput: one received byte per cycle; from an accepted end byte of a non-empty packet
// until the last store read is issued, full stays high, as it does while the command queue is
// full; readout gives one packet byte per cycle while the result queue has room, set by the
// single read port of the packet store
// reset: synchronous rst clears fill, flags and queues and loads the default codes; the store itself is not cleared
`timescale 1ns / 1ps
module escaped_serial_packet_deframer (
  input  logic                         clk,
  input  logic                         rst,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [espd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // received bytes
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   rx_byte,
  // results
  output logic                         empty,
  input  logic                         pop,
  output logic                         item_kind,
  output logic [7:0]                   data_byte,
  output logic [espd_pkg::IDX_W-1:0]   byte_index,
  output logic                         last_of_packet,
  output logic                         tx_blocked
);

  espd_pkg::cfg_t    cfg;
  espd_pkg::cmd_t    front_cmd;
  espd_pkg::cmd_t    q_head;
  espd_pkg::result_t res_head;
  logic [2:0]        reg_sel;
  logic              cfg_wr;
  logic              cmd_push, cmd_ready, cmd_valid, cmd_pop;
  logic              emit_done;
  logic              ram_we, ram_re;
  logic [espd_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // register file: one code byte per word, writes beyond the last register fall away
  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.end_code     <= 8'd13;
      cfg.newline_code <= 8'd10;
      cfg.escape_code  <= 8'd94;
      cfg.xoff_code    <= 8'd19;
      cfg.xon_code     <= 8'd17;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        espd_pkg::REG_END:     cfg.end_code     <= pwdata[7:0];
        espd_pkg::REG_NEWLINE: cfg.newline_code <= pwdata[7:0];
        espd_pkg::REG_ESCAPE:  cfg.escape_code  <= pwdata[7:0];
        espd_pkg::REG_XOFF:    cfg.xoff_code    <= pwdata[7:0];
        espd_pkg::REG_XON:     cfg.xon_code     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back of the code registers
  always_comb begin
    unique case (reg_sel)
      espd_pkg::REG_END:     prdata = {24'h0, cfg.end_code};
      espd_pkg::REG_NEWLINE: prdata = {24'h0, cfg.newline_code};
      espd_pkg::REG_ESCAPE:  prdata = {24'h0, cfg.escape_code};
      espd_pkg::REG_XOFF:    prdata = {24'h0, cfg.xoff_code};
      espd_pkg::REG_XON:     prdata = {24'h0, cfg.xon_code};
      default:               prdata = 32'h0;
    endcase
  end

  // front: classifies each byte, writes the packet store, queues work for the back
  espd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .rx_byte   (rx_byte),
    .full      (full),
    .cmd_ready (cmd_ready),
    .cmd_push  (cmd_push),
    .cmd       (front_cmd),
    .emit_done (emit_done),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  // decoupling queue of status and packet readout commands
  espd_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (front_cmd),
    .ready    (cmd_ready),
    .pop      (cmd_pop),
    .valid    (cmd_valid),
    .head     (q_head)
  );

  // packet store
  espd_ram #(
    .WIDTH (8),
    .DEPTH (espd_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // back: turns commands into result transactions
  espd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (q_head),
    .cmd_pop   (cmd_pop),
    .emit_done (emit_done),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .pop       (pop),
    .empty     (empty),
    .head      (res_head)
  );

  assign item_kind      = res_head.kind;
  assign data_byte      = res_head.data;
  assign byte_index     = res_head.index;
  assign last_of_packet = res_head.last;
  assign tx_blocked     = res_head.tx_blocked;

endmodule

FILE: sv/espd_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module espd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/espd_front.sv
// front end: byte classification, packet fill and flow control flag
`timescale 1ns / 1ps
module espd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  espd_pkg::cfg_t              cfg,
  input  logic                        push,
  input  logic [7:0]                  rx_byte,
  output logic                        full,
  input  logic                        cmd_ready,
  output logic                        cmd_push,
  output espd_pkg::cmd_t              cmd,
  input  logic                        emit_done,
  output logic                        ram_we,
  output logic [espd_pkg::ADDR_W-1:0] ram_waddr,
  output logic [7:0]                  ram_wdata
);

  logic [espd_pkg::FILL_W-1:0] fill, fill_next;
  logic esc_pend, esc_pend_next;
  logic discarding, discarding_next;
  logic tx_blk, tx_blk_next;
  logic emit_busy, emit_busy_next;
  logic accept;
  logic store_req;
  logic [7:0] store_val;
  logic [7:0] esc_val;

  assign full   = emit_busy | ~cmd_ready;
  assign accept = push & ~full;
  assign esc_val = (rx_byte == cfg.escape_code) ? rx_byte : (rx_byte & espd_pkg::LOW_FIVE);

  // classification in the fixed match order end, newline, xoff, xon, escape
  always_comb begin
    esc_pend_next   = esc_pend;
    discarding_next = discarding;
    tx_blk_next     = tx_blk;
    emit_busy_next  = emit_busy;
    store_req       = 1'b0;
    store_val       = rx_byte;
    cmd_push        = 1'b0;
    cmd.kind        = espd_pkg::KIND_STATUS;
    cmd.tx_blocked  = tx_blk;
    cmd.len         = fill;
    if (emit_done) begin
      emit_busy_next = 1'b0;
    end
    if (accept) begin
      priority if (esc_pend) begin
        esc_pend_next = 1'b0;
        store_req     = 1'b1;
        store_val     = esc_val;
      end else if (rx_byte == cfg.end_code) begin
        if (discarding) begin
          discarding_next = 1'b0;
        end else if (fill != '0) begin
          cmd_push       = 1'b1;
          cmd.kind       = espd_pkg::KIND_PACKET;
          emit_busy_next = 1'b1;
        end
      end else if (rx_byte == cfg.newline_code) begin
        store_req = ~discarding & (fill != '0);
      end else if (rx_byte == cfg.xoff_code) begin
        tx_blk_next    = 1'b1;
        cmd_push       = 1'b1;
        cmd.tx_blocked = 1'b1;
      end else if (rx_byte == cfg.xon_code) begin
        tx_blk_next    = 1'b0;
        cmd_push       = 1'b1;
        cmd.tx_blocked = 1'b0;
      end else if (rx_byte == cfg.escape_code) begin
        esc_pend_next = ~discarding;
      end else begin
        store_req = ~discarding;
      end
    end

    // fill pointer and overflow
    fill_next = fill;
    ram_we    = 1'b0;
    ram_waddr = fill[espd_pkg::ADDR_W-1:0];
    ram_wdata = store_val;
    if (accept && !esc_pend && rx_byte == cfg.end_code) begin
      fill_next = '0;
    end else if (store_req) begin
      if (fill < espd_pkg::FILL_W'(espd_pkg::STORE_DEPTH)) begin
        ram_we    = 1'b1;
        fill_next = fill + espd_pkg::FILL_W'(1);
      end else begin
        fill_next       = '0;
        discarding_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      esc_pend   <= 1'b0;
      discarding <= 1'b0;
      tx_blk     <= 1'b0;
      emit_busy  <= 1'b0;
    end else begin
      fill       <= fill_next;
      esc_pend   <= esc_pend_next;
      discarding <= discarding_next;
      tx_blk     <= tx_blk_next;
      emit_busy  <= emit_busy_next;
    end
  end

  a_no_write_during_readout: assert property (@(posedge clk) disable iff (rst)
    emit_busy |-> !ram_we) else $error("store written during packet readout");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= espd_pkg::FILL_W'(espd_pkg::STORE_DEPTH)) else $error("fill beyond store");

  a_no_escape_while_discarding: assert property (@(posedge clk) disable iff (rst)
    discarding |-> !esc_pend) else $error("escape pending while discarding");

endmodule

FILE: sv/espd_cmdq.sv
// short command queue between front and back
`timescale 1ns / 1ps
module espd_cmdq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  espd_pkg::cmd_t push_cmd,
  output logic           ready,
  input  logic           pop,
  output logic           valid,
  output espd_pkg::cmd_t head
);

  espd_pkg::cmd_t slots [espd_pkg::CMDQ_DEPTH];
  logic [espd_pkg::CMDQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [espd_pkg::CMDQ_CNT_W-1:0] count;
  logic do_push, do_pop;

  assign ready   = count != espd_pkg::CMDQ_CNT_W'(espd_pkg::CMDQ_DEPTH);
  assign valid   = count != '0;
  assign head    = slots[rd_ptr];
  assign do_push = push & ready;
  assign do_pop  = pop & valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + espd_pkg::CMDQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + espd_pkg::CMDQ_PTR_W'(1);
      end
      count <= count + espd_pkg::CMDQ_CNT_W'(do_push) - espd_pkg::CMDQ_CNT_W'(do_pop);
    end
  end

endmodule

FILE: sv/espd_back.sv
// back end: status results and packet readout into the result queue
`timescale 1ns / 1ps
module espd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  espd_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  output logic                        emit_done,
  output logic                        ram_re,
  output logic [espd_pkg::ADDR_W-1:0] ram_raddr,
  input  logic [7:0]                  ram_rdata,
  input  logic                        pop,
  output logic                        empty,
  output espd_pkg::result_t           head
);

  espd_pkg::back_state_t state, state_next;
  logic [espd_pkg::ADDR_W-1:0] rd_addr;
  logic [espd_pkg::FILL_W-1:0] len;
  logic tx_hold;
  logic rd_valid;
  logic [espd_pkg::ADDR_W-1:0] rd_idx;
  logic rd_last;

  espd_pkg::result_t out_slots [espd_pkg::OUT_DEPTH];
  logic [espd_pkg::OUT_PTR_W-1:0] out_wr, out_rd;
  logic [espd_pkg::OUT_CNT_W-1:0] out_count;

  logic room;
  logic issue, issue_last;
  logic status_push;
  logic out_push, out_pop;
  espd_pkg::result_t push_res;

  assign room = ({1'b0, out_count} + (espd_pkg::OUT_CNT_W + 1)'(rd_valid))
                < (espd_pkg::OUT_CNT_W + 1)'(espd_pkg::OUT_DEPTH);
  assign issue_last = (espd_pkg::FILL_W'(rd_addr) + espd_pkg::FILL_W'(1)) == len;

  always_comb begin
    state_next = state;
    unique case (state)
      espd_pkg::BK_IDLE: begin
        if (cmd_pop && cmd.kind == espd_pkg::KIND_PACKET) begin
          state_next = espd_pkg::BK_READ;
        end
      end
      espd_pkg::BK_READ: begin
        if (emit_done) begin
          state_next = espd_pkg::BK_IDLE;
        end
      end
      default: state_next = espd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop     = 1'b0;
    issue       = 1'b0;
    unique case (state)
      espd_pkg::BK_IDLE: begin
        cmd_pop = cmd_valid & ~rd_valid &
                  ((cmd.kind == espd_pkg::KIND_PACKET) ||
                   (out_count < espd_pkg::OUT_CNT_W'(espd_pkg::OUT_DEPTH)));
      end
      espd_pkg::BK_READ: begin
        issue = room;
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  assign status_push = cmd_pop & (cmd.kind == espd_pkg::KIND_STATUS);
  assign emit_done   = issue & issue_last;
  assign ram_re      = issue;
  assign ram_raddr   = rd_addr;

  always_comb begin
    if (rd_valid) begin
      push_res.kind       = espd_pkg::KIND_PACKET;
      push_res.data       = ram_rdata;
      push_res.index      = espd_pkg::IDX_W'(rd_idx);
      push_res.last       = rd_last;
      push_res.tx_blocked = tx_hold;
    end else begin
      push_res.kind       = espd_pkg::KIND_STATUS;
      push_res.data       = 8'h00;
      push_res.index      = '0;
      push_res.last       = 1'b0;
      push_res.tx_blocked = cmd.tx_blocked;
    end
  end

  assign out_push = rd_valid | status_push;
  assign empty    = out_count == '0;
  assign out_pop  = pop & ~empty;
  assign head     = out_slots[out_rd];

  always_ff @(posedge clk) begin
    if (out_push) begin
      out_slots[out_wr] <= push_res;
    end
    if (cmd_pop && cmd.kind == espd_pkg::KIND_PACKET) begin
      len     <= cmd.len;
      tx_hold <= cmd.tx_blocked;
    end
    if (issue) begin
      rd_idx  <= rd_addr;
      rd_last <= issue_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= espd_pkg::BK_IDLE;
      rd_addr   <= '0;
      rd_valid  <= 1'b0;
      out_wr    <= '0;
      out_rd    <= '0;
      out_count <= '0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (cmd_pop) begin
        rd_addr <= '0;
      end else if (issue) begin
        rd_addr <= rd_addr + espd_pkg::ADDR_W'(1);
      end
      if (out_push) begin
        out_wr <= out_wr + espd_pkg::OUT_PTR_W'(1);
      end
      if (out_pop) begin
        out_rd <= out_rd + espd_pkg::OUT_PTR_W'(1);
      end
      out_count <= out_count + espd_pkg::OUT_CNT_W'(out_push)
                   - espd_pkg::OUT_CNT_W'(out_pop);
    end
  end

  a_out_bound: assert property (@(posedge clk) disable iff (rst)
    out_count <= espd_pkg::OUT_CNT_W'(espd_pkg::OUT_DEPTH)) else $error("result queue overrun");

  a_single_writer: assert property (@(posedge clk) disable iff (rst)
    !(rd_valid && status_push)) else $error("two pushes into result queue");

  a_no_pop_in_readout: assert property (@(posedge clk) disable iff (rst)
    (state == espd_pkg::BK_READ) |-> !cmd_pop) else $error("command taken during readout");

endmodule

FILE: test/espd_tb_pkg.sv
// scoreboard with a byte-level predictor for the packet deframer testbench
`timescale 1ns / 1ps
package espd_tb_pkg;

  localparam espd_pkg::cfg_t RESET_CODES = '{end_code: 8'd13, newline_code: 8'd10,
                                             escape_code: 8'd94, xoff_code: 8'd19,
                                             xon_code: 8'd17};

  class deframer_scoreboard;
    espd_pkg::cfg_t    codes;
    logic [7:0]        packet_bytes [espd_pkg::STORE_DEPTH];
    int                fill;
    bit                escape_armed;
    bit                dropping;
    bit                blocked;
    espd_pkg::result_t due [$];
    int                errors;
    int                checked;
    int                status_seen;

    function new();
      codes        = RESET_CODES;
      fill         = 0;
      escape_armed = 1'b0;
      dropping     = 1'b0;
      blocked      = 1'b0;
      errors       = 0;
      checked      = 0;
      status_seen  = 0;
    endfunction

    function void set_reg(int unsigned idx, logic [31:0] value);
      case (idx)
        espd_pkg::REG_END:     codes.end_code     = value[7:0];
        espd_pkg::REG_NEWLINE: codes.newline_code = value[7:0];
        espd_pkg::REG_ESCAPE:  codes.escape_code  = value[7:0];
        espd_pkg::REG_XOFF:    codes.xoff_code    = value[7:0];
        espd_pkg::REG_XON:     codes.xon_code     = value[7:0];
        default:     ;
      endcase
    endfunction

    function bit is_code(logic [7:0] b);
      return b == codes.end_code || b == codes.newline_code || b == codes.escape_code ||
             b == codes.xoff_code || b == codes.xon_code;
    endfunction

    function void keep_byte(logic [7:0] b);
      if (fill < espd_pkg::STORE_DEPTH) begin
        packet_bytes[fill] = b;
        fill++;
      end else begin
        fill     = 0;
        dropping = 1'b1;
      end
    endfunction

    function void add_status();
      due.push_back('{kind: espd_pkg::KIND_STATUS, data: 8'h00, index: '0, last: 1'b0,
                      tx_blocked: blocked});
    endfunction

    // one accepted received byte
    function void take_byte(logic [7:0] rx);
      logic [7:0] b;
      b = rx;
      if (escape_armed) begin
        escape_armed = 1'b0;
        if (b != codes.escape_code) b = b & espd_pkg::LOW_FIVE;
        keep_byte(b);
      end else if (b == codes.end_code) begin
        if (dropping) begin
          dropping = 1'b0;
        end else begin
          for (int i = 0; i < fill; i++)
            due.push_back('{kind: espd_pkg::KIND_PACKET, data: packet_bytes[i],
                            index: espd_pkg::IDX_W'(i), last: (i == fill - 1),
                            tx_blocked: blocked});
        end
        fill = 0;
      end else if (b == codes.newline_code) begin
        if (!dropping && fill != 0) keep_byte(b);
      end else if (b == codes.xoff_code) begin
        blocked = 1'b1;
        add_status();
      end else if (b == codes.xon_code) begin
        blocked = 1'b0;
        add_status();
      end else if (b == codes.escape_code) begin
        if (!dropping) escape_armed = 1'b1;
      end else if (!dropping) begin
        keep_byte(b);
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s expected %0h got %0h", name, want, got);
        errors++;
      end
    endfunction

    // one accepted result
    function void match_result(espd_pkg::result_t got);
      espd_pkg::result_t want;
      if (due.size() == 0) begin
        $error("unexpected result: item_kind %0d data_byte %0h byte_index %0d",
               got.kind, got.data, got.index);
        errors++;
        return;
      end
      want = due.pop_front();
      checked++;
      if (want.kind == espd_pkg::KIND_STATUS) status_seen++;
      compare_field("item_kind", 8'(want.kind), 8'(got.kind));
      compare_field("data_byte", want.data, got.data);
      compare_field("byte_index", 8'(want.index), 8'(got.index));
      compare_field("last_of_packet", 8'(want.last), 8'(got.last));
      compare_field("tx_blocked", 8'(want.tx_blocked), 8'(got.tx_blocked));
    endfunction
  endclass

endpackage

FILE: test/tb.sv
// testbench top for the escaped serial packet deframer
`timescale 1ns / 1ps
module tb;

  localparam int CYCLE_LIMIT   = 400000;
  // covers a status result plus the store read pipeline after the last end byte
  localparam int SETTLE_CYCLES = 12;
  // addresses past the register file, writes there must change nothing
  localparam int UNUSED_REG_LO = 5;
  localparam int UNUSED_REG_HI = 7;

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [espd_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;
  logic                         push;
  logic                         full;
  logic [7:0]                   rx_byte;
  logic                         empty;
  logic                         pop;
  logic                         item_kind;
  logic [7:0]                   data_byte;
  logic [espd_pkg::IDX_W-1:0]   byte_index;
  logic                         last_of_packet;
  logic                         tx_blocked;

  espd_tb_pkg::deframer_scoreboard sb = new();
  bit                 calm = 1'b0;   // no idling on either side once set
  int                 bytes_sent = 0;
  int                 cycles = 0;

  escaped_serial_packet_deframer dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog, falls through only on a hang
  initial begin
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  // result side: sample the transaction at the edge, then pick pop for the next cycle
  initial begin
    int                stall_left;
    espd_pkg::result_t got;
    stall_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got = '{kind: item_kind, data: data_byte, index: byte_index, last: last_of_packet,
                tx_blocked: tx_blocked};
        sb.match_result(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 12) begin
        // stall burst
        stall_left = $urandom_range(0, 16);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // byte that matches none of the current codes
  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    do v = 8'($urandom); while (sb.is_code(v));
    return v;
  endfunction

  // holds push until the byte is taken; push stays high when the next byte follows at once
  task automatic send_byte(logic [7:0] b);
    push    <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    sb.take_byte(b);
    bytes_sent++;
    if (!calm && $urandom_range(0, 99) < 15) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // setup then access phase; psel is left high so back-to-back writes need no extra edge
  task automatic reg_write(int unsigned idx, logic [7:0] value);
    logic [31:0] word;
    word = {24'($urandom), value};   // upper bits are junk the block must drop
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= espd_pkg::PADDR_W'(idx * 4);
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, word);
  endtask

  task automatic load_codes(espd_pkg::cfg_t c, bit poke_unused);
    if (poke_unused) begin
      reg_write(UNUSED_REG_LO, 8'($urandom));
      reg_write(UNUSED_REG_HI, 8'($urandom));
    end
    reg_write(espd_pkg::REG_END, c.end_code);
    reg_write(espd_pkg::REG_NEWLINE, c.newline_code);
    reg_write(espd_pkg::REG_ESCAPE, c.escape_code);
    reg_write(espd_pkg::REG_XOFF, c.xoff_code);
    reg_write(espd_pkg::REG_XON, c.xon_code);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // registers change only once every expected transaction is out and the readout is quiet
  task automatic settle();
    push <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // packet body with some escapes, newlines and flow control mixed in, then the end byte
  task automatic send_packet(int len, bit plain_only);
    int roll;
    for (int i = 0; i < len; i++) begin
      roll = plain_only ? 99 : $urandom_range(0, 99);
      if (roll < 8) begin
        send_byte(sb.codes.escape_code);
        send_byte(8'($urandom));
      end else if (roll < 12) begin
        send_byte(sb.codes.newline_code);
      end else if (roll < 16) begin
        send_byte($urandom_range(0, 1) ? sb.codes.xoff_code : sb.codes.xon_code);
      end else begin
        send_byte(plain_byte());
      end
    end
    send_byte(sb.codes.end_code);
  endtask

  // mostly short packets, now and then one near or past the store size, and bursts of noise
  task automatic random_traffic(int budget);
    int stop_at;
    int len;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 99) < 12) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else begin
        len = ($urandom_range(0, 99) < 3) ? $urandom_range(56, 70) : $urandom_range(0, 10);
        send_packet(len, 1'b0);
      end
    end
  endtask

  // fill the store, overflow it with an escaped byte, then poke every code while dropping
  task automatic overflow_run();
    for (int i = 0; i < espd_pkg::STORE_DEPTH; i++) send_byte(plain_byte());
    send_byte(sb.codes.escape_code);
    send_byte(8'($urandom));
    send_byte(sb.codes.escape_code);   // no escape while dropping
    send_byte(plain_byte());
    send_byte(sb.codes.newline_code);
    send_byte(sb.codes.xoff_code);     // status still reported while dropping
    send_byte(sb.codes.xoff_code);     // same flag value, still reported
    send_byte(sb.codes.xon_code);
    send_byte(sb.codes.end_code);      // ends dropping, no packet
    send_byte(plain_byte());
    send_byte(sb.codes.end_code);
  endtask

  // reset codes: field extremes, escapes, flow control and empty packets
  task automatic directed_opening();
    logic [7:0] e, nl, esc, xf, xn;
    e   = sb.codes.end_code;
    nl  = sb.codes.newline_code;
    esc = sb.codes.escape_code;
    xf  = sb.codes.xoff_code;
    xn  = sb.codes.xon_code;
    send_byte(nl);                   // newline first in packet is dropped
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(nl);                   // newline inside a packet is kept
    send_byte(esc);
    send_byte(8'hff);                // escaped byte keeps its low five bits
    send_byte(esc);
    send_byte(esc);                  // escaped escape code stays whole
    send_byte(esc);
    send_byte(e);                    // escaped end byte is plain data
    send_byte(xf);
    send_byte(xf);
    send_byte(xn);
    send_byte(esc);
    send_byte(xf);                   // escaped xoff is data, no status
    send_byte(e);                    // seven byte packet
    send_byte(e);                    // empty store, nothing out
    send_byte(8'h41);
    send_byte(e);                    // single byte packet
    send_byte(xf);                   // next packet carries the blocked flag
    send_byte(8'h7f);
    send_byte(8'h80);
    send_byte(e);
    send_byte(xn);
  endtask

  initial begin
    espd_pkg::cfg_t extreme_codes;
    espd_pkg::cfg_t tied_codes;
    espd_pkg::cfg_t random_codes;
    extreme_codes = '{end_code: 8'h00, newline_code: 8'hff, escape_code: 8'h80,
                      xoff_code: 8'h01, xon_code: 8'hfe};
    // newline shadows xoff and xon shadows escape
    tied_codes    = '{end_code: 8'hff, newline_code: 8'h33, escape_code: 8'h44,
                      xoff_code: 8'h33, xon_code: 8'h44};
    random_codes  = '{end_code: 8'($urandom), newline_code: 8'($urandom),
                      escape_code: 8'($urandom), xoff_code: 8'($urandom),
                      xon_code: 8'($urandom)};
    rst     <= 1'b1;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    push    <= 1'b0;
    rx_byte <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset codes
    directed_opening();
    overflow_run();
    random_traffic(5);
    settle();

    // code extremes, plus writes past the register file
    load_codes(extreme_codes, 1'b1);
    random_traffic(5);
    settle();

    // tied codes to exercise match priority
    load_codes(tied_codes, 1'b0);
    random_traffic(5);
    settle();

    load_codes(random_codes, 1'b0);
    random_traffic(5);
    settle();

    // back to reset codes, both sides at full rate
    load_codes(espd_tb_pkg::RESET_CODES, 1'b0);
    calm = 1'b1;
    random_traffic(5);
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d received bytes and %0d result transactions (%0d status)",
             bytes_sent, sb.checked, sb.status_seen);
    $display("across five code settings: reset, extremes, tied codes, random, full rate");
    if (sb.errors == 0 && sb.due.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
